// File: rtl/tbc_pkg.sv
package tbc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W   = 8;
   localparam int SIZE_W  = 11;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COUNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int QUOT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int SUM_W   = QUOT_W + COUNT_W - 1;
   localparam int STEP_W  = $clog2(QUOT_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   // highlight, center_col, center_row, hit_count, padded to whole bytes
   localparam int RSP_BITS = 1 + COL_W + ROW_W + COUNT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 8'd254;
   localparam logic [SIZE_W-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 11'd480;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_COL,
      ST_DIV_ROW
   } state_type;

endpackage

// File: rtl/threshold_blob_centroid_top.sv
// A pixel that does not end its frame has its result registered in the cycle after acceptance.
// The last pixel of a frame with hits gives its result once the division is done:
// one restoring divider, one quotient bit per cycle, runs for column then row.
// Throughput: one pixel per cycle inside a frame unless the output stalls; the divider holds off input
// after the last pixel of a frame with hits. A frame without hits does not hold off input.
// Reset (synchronous, active high) clears counters and sums and loads the register defaults.
module threshold_blob_centroid_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tbc_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel_value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] highlight, [10:1] center_col, [20:11] center_row, [41:21] hit_count, rest zero
   output logic [tbc_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tlast,   // frame_done
   output logic                             rsp_tuser,   // [0] center_valid
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tbc_pkg::*;

   // configuration
   logic [PIX_W-1:0]  threshold_ff, threshold_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;

   // frame state
   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [SUM_W-1:0]  col_sum_ff, col_sum_in;
   logic [SUM_W-1:0]  row_sum_ff, row_sum_in;
   logic [COUNT_W-1:0] hit_total_ff, hit_total_in;

   // shared divider
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W:0]    dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COL_W-1:0]  ccol_ff, ccol_in;
   logic              last_hl_ff, last_hl_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              o_hl_ff, o_hl_in;
   logic              o_done_ff, o_done_in;
   logic              o_cv_ff, o_cv_in;
   logic [COL_W-1:0]  o_col_ff, o_col_in;
   logic [ROW_W-1:0]  o_row_ff, o_row_in;
   logic [COUNT_W-1:0] o_cnt_ff, o_cnt_in;

   logic              accept;
   logic              hit;
   logic [COL_W-1:0]  col_last;
   logic [ROW_W-1:0]  row_last;
   logic              row_end;
   logic              frame_end;
   logic [SUM_W-1:0]  col_sum_upd;
   logic [SUM_W-1:0]  row_sum_upd;
   logic [COUNT_W-1:0] hit_upd;
   logic              div_ge;
   logic [QUOT_W-1:0] quot_next;
   logic              div_last;

   // clamp the frame size to 1..MAX, as last index
   always_comb begin
      if (width_ff == '0) begin
         col_last = '0;
      end else if (32'(width_ff) >= MAX_WIDTH) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         row_last = '0;
      end else if (32'(height_ff) >= MAX_HEIGHT) begin
         row_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_W'(height_ff - 1'b1);
      end
   end

   assign accept      = req_tvalid && req_tready;
   assign hit         = req_tdata > threshold_ff;
   assign row_end     = col_cnt_ff >= col_last;
   assign frame_end   = row_end && (row_cnt_ff >= row_last);
   assign col_sum_upd = hit ? col_sum_ff + SUM_W'(col_cnt_ff) : col_sum_ff;
   assign row_sum_upd = hit ? row_sum_ff + SUM_W'(row_cnt_ff) : row_sum_ff;
   assign hit_upd     = hit ? hit_total_ff + 1'b1 : hit_total_ff;

   assign div_ge    = {1'b0, rem_ff} >= dsh_ff;
   assign quot_next = {quot_ff[QUOT_W-2:0], div_ge};
   assign div_last  = step_ff == STEP_W'(QUOT_W - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && frame_end && hit_upd != '0) begin
               state_in = ST_DIV_COL;
            end
         end
         ST_DIV_COL: begin
            if (div_last) begin
               state_in = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (div_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready = !rsp_valid_ff || rsp_tready;
         ST_DIV_COL: req_tready = 1'b0;
         ST_DIV_ROW: req_tready = 1'b0;
         default:    req_tready = 1'b0;
      endcase
   end

   assign csr_ready = 1'b1;

   // configuration writes
   always_comb begin
      threshold_in = threshold_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_data[PIX_W-1:0];
            CSR_WIDTH:     width_in     = csr_data;
            CSR_HEIGHT:    height_in    = csr_data;
            default:       ;
         endcase
      end
   end

   // datapath
   always_comb begin
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      col_sum_in   = col_sum_ff;
      row_sum_in   = row_sum_ff;
      hit_total_in = hit_total_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      ccol_in      = ccol_ff;
      last_hl_in   = last_hl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      o_hl_in      = o_hl_ff;
      o_done_in    = o_done_ff;
      o_cv_in      = o_cv_ff;
      o_col_in     = o_col_ff;
      o_row_in     = o_row_ff;
      o_cnt_in     = o_cnt_ff;

      if (state_ff == ST_IDLE) begin
         if (accept) begin
            if (frame_end) begin
               col_cnt_in = '0;
               row_cnt_in = '0;
               if (hit_upd != '0) begin
                  // hold the sums, start the column division
                  col_sum_in   = col_sum_upd;
                  row_sum_in   = row_sum_upd;
                  hit_total_in = hit_upd;
                  last_hl_in   = hit;
                  rem_in       = col_sum_upd;
                  dsh_in       = (SUM_W + 1)'(hit_upd) << (QUOT_W - 1);
                  quot_in      = '0;
                  step_in      = '0;
               end else begin
                  col_sum_in   = '0;
                  row_sum_in   = '0;
                  hit_total_in = '0;
                  rsp_valid_in = 1'b1;
                  o_hl_in      = hit;
                  o_done_in    = 1'b1;
                  o_cv_in      = 1'b0;
                  o_col_in     = '0;
                  o_row_in     = '0;
                  o_cnt_in     = '0;
               end
            end else begin
               if (row_end) begin
                  col_cnt_in = '0;
                  row_cnt_in = row_cnt_ff + 1'b1;
               end else begin
                  col_cnt_in = col_cnt_ff + 1'b1;
               end
               col_sum_in   = col_sum_upd;
               row_sum_in   = row_sum_upd;
               hit_total_in = hit_upd;
               rsp_valid_in = 1'b1;
               o_hl_in      = hit;
               o_done_in    = 1'b0;
               o_cv_in      = 1'b0;
               o_col_in     = '0;
               o_row_in     = '0;
               o_cnt_in     = '0;
            end
         end
      end else begin
         // one restoring step: subtract the shifted divisor when it fits
         if (div_ge) begin
            rem_in = rem_ff - dsh_ff[SUM_W-1:0];
         end
         dsh_in  = dsh_ff >> 1;
         quot_in = quot_next;
         step_in = step_ff + 1'b1;
         if (div_last) begin
            if (state_ff == ST_DIV_COL) begin
               ccol_in = COL_W'(quot_next);
               rem_in  = row_sum_ff;
               dsh_in  = (SUM_W + 1)'(hit_total_ff) << (QUOT_W - 1);
               quot_in = '0;
               step_in = '0;
            end else begin
               rsp_valid_in = 1'b1;
               o_hl_in      = last_hl_ff;
               o_done_in    = 1'b1;
               o_cv_in      = 1'b1;
               o_col_in     = ccol_ff;
               o_row_in     = ROW_W'(quot_next);
               o_cnt_in     = hit_total_ff;
               col_sum_in   = '0;
               row_sum_in   = '0;
               hit_total_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         state_ff     <= ST_IDLE;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         col_sum_ff   <= '0;
         row_sum_ff   <= '0;
         hit_total_ff <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         state_ff     <= state_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         col_sum_ff   <= col_sum_in;
         row_sum_ff   <= row_sum_in;
         hit_total_ff <= hit_total_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quot_ff    <= quot_in;
      ccol_ff    <= ccol_in;
      last_hl_ff <= last_hl_in;
      o_hl_ff    <= o_hl_in;
      o_done_ff  <= o_done_in;
      o_cv_ff    <= o_cv_in;
      o_col_ff   <= o_col_in;
      o_row_ff   <= o_row_in;
      o_cnt_ff   <= o_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_done_ff;
   assign rsp_tuser  = o_cv_ff;
   assign rsp_tdata  = {(RSP_W - RSP_BITS)'(0), o_cnt_ff, o_row_ff, o_col_ff, o_hl_ff};

   a_no_result_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while divider busy");

   a_center_needs_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_cv_ff) |-> (o_done_ff && o_cnt_ff != '0))
      else $error("center reported without frame end or hits");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= STEP_W'(QUOT_W - 1)))
      else $error("divider step out of range");

   a_divider_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_ROW && div_last) |=> (rsp_valid_ff && o_done_ff && o_cv_ff))
      else $error("division finished without a frame result");

endmodule

// File: tb/sv/threshold_blob_centroid_top_tb.sv
`timescale 1ns / 1ps

module threshold_blob_centroid_top_tb;
   import tbc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 2 * QUOT_W + 9;
   localparam int RANDOM_PIXELS = 280;

   typedef enum int {
      MIX_DARK,
      MIX_BRIGHT,
      MIX_SPARSE,
      MIX_NOISE
   } pixel_mix_type;

   typedef struct packed {
      logic               highlight;
      logic               frame_done;
      logic               center_valid;
      logic [COL_W-1:0]   center_col;
      logic [ROW_W-1:0]   center_row;
      logic [COUNT_W-1:0] hit_count;
   } pixel_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;    // [7:0] pixel_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] highlight, [10:1] center_col, [20:11] center_row, [41:21] hit_count, rest zero
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;    // frame_done
   logic                  rsp_tuser;    // [0] center_valid
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // centroid predictor: configuration and frame state
   logic [PIX_W-1:0]  thresh_cfg = THRESHOLD_RESET;
   logic [SIZE_W-1:0] width_cfg  = WIDTH_RESET;
   logic [SIZE_W-1:0] height_cfg = HEIGHT_RESET;
   logic [COL_W-1:0]  col_pos    = '0;
   logic [ROW_W-1:0]  row_pos    = '0;
   longint unsigned   col_acc    = 0;
   longint unsigned   row_acc    = 0;
   int unsigned       hit_acc    = 0;
   logic              frame_closed = 1'b0;

   pixel_result_type pending_results[$];

   int  mismatches   = 0;
   int  pixels_sent  = 0;
   int  frames_done  = 0;
   int  hit_frames   = 0;
   int  csr_writes   = 0;
   int  cycle_count  = 0;
   int  rsp_stall    = 0;
   bit  input_quiet  = 1'b0;
   bit  rsp_quiet    = 1'b0;

   threshold_blob_centroid_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("threshold_blob_centroid_top verification failed");
         $finish;
      end
   end

   function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int maxv);
      if (v == 0)
         return 1;
      if (int'(v) > maxv)
         return maxv;
      return int'(v);
   endfunction

   task automatic predict_pixel(input logic [PIX_W-1:0] pix);
      pixel_result_type want;
      int               w;
      int               h;
      logic             hit;
      logic             row_end;
      logic             frame_end;
      longint unsigned  quot;
      w = clamp_dim(width_cfg, MAX_WIDTH);
      h = clamp_dim(height_cfg, MAX_HEIGHT);
      hit = pix > thresh_cfg;
      want = '0;
      want.highlight = hit;
      if (hit) begin
         col_acc += col_pos;
         row_acc += row_pos;
         hit_acc++;
      end
      row_end = int'(col_pos) >= w - 1;
      frame_end = row_end && (int'(row_pos) >= h - 1);
      if (frame_end) begin
         want.frame_done = 1'b1;
         frames_done++;
         if (hit_acc != 0) begin
            want.center_valid = 1'b1;
            quot = col_acc / hit_acc;
            want.center_col = quot[COL_W-1:0];
            quot = row_acc / hit_acc;
            want.center_row = quot[ROW_W-1:0];
            quot = hit_acc;
            want.hit_count = quot[COUNT_W-1:0];
            hit_frames++;
         end
         col_pos = '0;
         row_pos = '0;
         col_acc = 0;
         row_acc = 0;
         hit_acc = 0;
      end else if (row_end) begin
         col_pos = '0;
         row_pos++;
      end else begin
         col_pos++;
      end
      frame_closed = frame_end;
      pending_results.push_back(want);
      pixels_sent++;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mix_type mix);
      int thr;
      thr = int'(thresh_cfg);
      case (mix)
         MIX_DARK:   return PIX_W'($urandom_range(0, thr));
         MIX_BRIGHT: return (thr == 255) ? 8'hFF : PIX_W'($urandom_range(thr + 1, 255));
         MIX_SPARSE: begin
            if ($urandom_range(0, 7) == 0 && thr < 255)
               return PIX_W'($urandom_range(thr + 1, 255));
            return PIX_W'($urandom_range(0, thr));
         end
         default:    return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = input_quiet ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pix;
      do @(posedge clock); while (!req_tready);
      predict_pixel(pix);
   endtask

   // hold input until every expected beat has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_THRESHOLD: thresh_cfg = data[PIX_W-1:0];
         CSR_WIDTH:     width_cfg  = data;
         CSR_HEIGHT:    height_cfg = data;
         default:       ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_dark(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 100 == 0)
            input_quiet = $urandom_range(0, 1);
         send_pixel(pick_pixel(MIX_DARK));
      end
   endtask

   task automatic finish_frame(input pixel_mix_type mix);
      while (!frame_closed)
         send_pixel(pick_pixel(mix));
   endtask

   task automatic note_mismatch(input string what, input pixel_result_type want,
                                input pixel_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at cycle %0d: expected hl=%0b done=%0b cv=%0b col=%0d row=%0d cnt=%0d,",
                  what, cycle_count,
                  want.highlight, want.frame_done, want.center_valid,
                  want.center_col, want.center_row, want.hit_count);
         $display("   got hl=%0b done=%0b cv=%0b col=%0d row=%0d cnt=%0d",
                  got.highlight, got.frame_done, got.center_valid,
                  got.center_col, got.center_row, got.hit_count);
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.highlight    = rsp_tdata[0];
         got.center_col   = rsp_tdata[COL_W:1];
         got.center_row   = rsp_tdata[COL_W+ROW_W:COL_W+1];
         got.hit_count    = rsp_tdata[RSP_BITS-1:COL_W+ROW_W+1];
         got.frame_done   = rsp_tlast;
         got.center_valid = rsp_tuser;
         rsp_stall = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               note_mismatch("result mismatch", want, got);
            else if (rsp_tdata[RSP_W-1:RSP_BITS] !== '0)
               note_mismatch("nonzero pad bits", want, got);
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // defaults after reset, threshold equality, then a resize in the middle of a frame
   task automatic test_reset_defaults();
      send_pixel(8'd0);
      send_pixel(8'd254);
      send_pixel(8'd255);
      wait_idle();
      write_csr(CSR_WIDTH, 11'd4);
      write_csr(CSR_HEIGHT, 11'd2);
      send_pixel(8'd255);
      send_pixel(8'd10);
      send_pixel(8'd255);
      send_pixel(8'd254);
      send_pixel(8'd255);
   endtask

   task automatic test_threshold_edges();
      wait_idle();
      write_csr(CSR_THRESHOLD, 11'd0);
      write_csr(CSR_WIDTH, 11'd3);
      write_csr(CSR_HEIGHT, 11'd1);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'd0);
      wait_idle();
      // nothing passes a threshold of 255: frame without hits
      write_csr(CSR_THRESHOLD, 11'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
   endtask

   task automatic test_size_clamp();
      wait_idle();
      write_csr(CSR_WIDTH, 11'd0);
      write_csr(CSR_HEIGHT, 11'd0);
      write_csr(CSR_THRESHOLD, 11'h7FF);
      write_csr(CSR_UNUSED, 11'h5A5);
      send_pixel(8'd255);
      wait_idle();
      write_csr(CSR_THRESHOLD, 11'h400);
      send_pixel(8'd128);
      send_pixel(8'd0);
   endtask

   // full-width row: sizes above the maximum, height dropped mid-frame
   task automatic test_widest_row();
      wait_idle();
      write_csr(CSR_THRESHOLD, 11'd200);
      write_csr(CSR_WIDTH, 11'h7FF);
      write_csr(CSR_HEIGHT, 11'h7FF);
      send_dark(1000);
      wait_idle();
      write_csr(CSR_HEIGHT, 11'd0);
      input_quiet = 1'b0;
      finish_frame(MIX_NOISE);
   endtask

   // one pixel per row, height just above the maximum, then cut short mid-frame
   task automatic test_tallest_column();
      wait_idle();
      write_csr(CSR_THRESHOLD, 11'd100);
      write_csr(CSR_WIDTH, 11'd1);
      write_csr(CSR_HEIGHT, 11'd1030);
      send_dark(140);
      wait_idle();
      write_csr(CSR_HEIGHT, 11'd151);
      input_quiet = 1'b0;
      finish_frame(MIX_NOISE);
   endtask

   task automatic test_random_frames();
      int            start;
      int            sent;
      int            resize_at;
      int            pick;
      bit            first;
      pixel_mix_type mix;
      start = pixels_sent;
      first = 1'b1;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         if (first || $urandom_range(0, 1) == 0) begin
            wait_idle();
            pick = $urandom_range(0, 3);
            write_csr(CSR_THRESHOLD, (pick == 0) ? 11'd0 : (pick == 1) ? 11'd255 :
                                     CSR_DATA_W'($urandom_range(0, 2047)));
            if (first || $urandom_range(0, 1) == 0)
               write_csr(CSR_WIDTH, CSR_DATA_W'($urandom_range(0, 9)));
            if (first || $urandom_range(0, 1) == 0)
               write_csr(CSR_HEIGHT, CSR_DATA_W'($urandom_range(0, 6)));
            if ($urandom_range(0, 7) == 0)
               write_csr(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 2047)));
            first = 1'b0;
         end
         mix = pixel_mix_type'($urandom_range(0, 3));
         input_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         resize_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : -1;
         sent = 0;
         frame_closed = 1'b0;
         while (!frame_closed) begin
            if (sent == resize_at) begin
               wait_idle();
               write_csr(CSR_WIDTH, CSR_DATA_W'($urandom_range(0, 9)));
               write_csr(CSR_HEIGHT, CSR_DATA_W'($urandom_range(0, 6)));
            end
            send_pixel(pick_pixel(mix));
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_threshold_edges();
      test_size_clamp();
      test_widest_row();
      test_tallest_column();
      test_random_frames();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         $display("%0d expected results never arrived", pending_results.size());

      $display("covered %0d pixels in %0d frames (%0d with hits), %0d register writes",
               pixels_sent, frames_done, hit_frames, csr_writes);
      $display("sizes 1x1 up to a 1024-wide row, oversized and zero sizes, mid-frame resizes");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("threshold_blob_centroid_top verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("threshold_blob_centroid_top verification failed");
      end
      $finish;
   end

endmodule
